// File: rtl/hma_pkg.sv
// ----------------------------------------------------------------------------
// hma_pkg
// Shared types and codes of the histogram merge accumulator.
// ----------------------------------------------------------------------------
package hma_pkg;

   typedef enum logic [2:0] {
      REG_HEADER  = 3'd0,
      REG_ENTRIES = 3'd1,
      REG_CONTENT = 3'd2,
      REG_ERROR   = 3'd3,
      REG_SQUARED = 3'd4
   } region_type;

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_ACCUM = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   // The spare op code behaves as a read.
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic [1:0] KIND_1D   = 2'd0;
   localparam logic [1:0] KIND_2D   = 2'd1;
   localparam logic [1:0] KIND_PROF = 2'd2;
   // No layout: every index is out of range.
   localparam logic [1:0] KIND_NONE = 2'd3;

   localparam logic [1:0] CSR_KIND   = 2'd0;
   localparam logic [1:0] CSR_BINS_X = 2'd1;
   localparam logic [1:0] CSR_BINS_Y = 2'd2;

   localparam int SQRT_STEPS = 32;
   // Square, square, sum, then one register per root bit.
   localparam int QUAD_LAT   = 3 + SQRT_STEPS;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // One word in flight through the tail of the pipeline.
   typedef struct packed {
      logic              v;
      logic              wr;
      logic              pend;
      logic [11:0]       idx;
      logic [31:0]       data;
      region_type        region;
      logic              oor;
      logic              sat;
   } rec_type;

   typedef struct packed {
      logic [31:0] data;
      region_type  region;
      logic        oor;
      logic        sat;
   } rsp_type;

endpackage

// File: rtl/hma_if.sv
// ----------------------------------------------------------------------------
// hma_if
// Request and response channels of the histogram merge accumulator.
// ----------------------------------------------------------------------------
interface hma_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [11:0]        word_index;
   logic signed [31:0] value;

   modport source (output valid, output op, output word_index, output value, input ready);
   modport sink   (input valid, input op, input word_index, input value, output ready);
endinterface

interface hma_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [2:0]         region;
   logic               out_of_range;
   logic               saturated;

   modport source (output valid, output result_value, output region, output out_of_range,
                   output saturated, input ready);
   modport sink   (input valid, input result_value, input region, input out_of_range,
                   input saturated, output ready);
endinterface

// File: rtl/hma_quad_pipe.sv
// ----------------------------------------------------------------------------
// hma_quad_pipe
// Pipelined floor(sqrt(a*a + b*b)), one root bit per stage, clamped to 31 bits.
// ----------------------------------------------------------------------------
module hma_quad_pipe (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] root,
   output logic        sat
);

   logic [63:0] sq_a_ff, sq_a2_ff, sq_b_ff;
   logic [31:0] b_ff;
   logic [63:0] x_ff   [0:hma_pkg::SQRT_STEPS];
   logic [63:0] res_ff [0:hma_pkg::SQRT_STEPS];
   logic [63:0] x_in   [0:hma_pkg::SQRT_STEPS-1];
   logic [63:0] res_in [0:hma_pkg::SQRT_STEPS-1];

   always_comb begin
      logic [63:0] bit_v;
      logic [63:0] trial;
      for (int k = 0; k < hma_pkg::SQRT_STEPS; k++) begin
         bit_v = 64'd1 << (62 - 2 * k);
         trial = res_ff[k] + bit_v;
         if (x_ff[k] >= trial) begin
            x_in[k]   = x_ff[k] - trial;
            res_in[k] = (res_ff[k] >> 1) + bit_v;
         end else begin
            x_in[k]   = x_ff[k];
            res_in[k] = res_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_a_ff   <= 64'(a) * 64'(a);
         b_ff      <= b;
         sq_a2_ff  <= sq_a_ff;
         sq_b_ff   <= 64'(b_ff) * 64'(b_ff);
         x_ff[0]   <= sq_a2_ff + sq_b_ff;
         res_ff[0] <= 64'd0;
         for (int k = 0; k < hma_pkg::SQRT_STEPS; k++) begin
            x_ff[k+1]   <= x_in[k];
            res_ff[k+1] <= res_in[k];
         end
      end
   end

   assign sat  = res_ff[hma_pkg::SQRT_STEPS] > 64'(hma_pkg::S32_MAX);
   assign root = sat ? hma_pkg::S32_MAX : res_ff[hma_pkg::SQRT_STEPS][31:0];

endmodule

// File: rtl/histogram_merge_accumulator.sv
// ----------------------------------------------------------------------------
// histogram_merge_accumulator
// Merges histogram buffer words into a sum store by layout region.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle, set by the 35-stage quadrature tail, while the
// output is not stalled; a word whose index is still in flight in the tail waits
// in the compute stage until that earlier word has been written to the store.
// Reset clears control state and valid flags; the store is not cleared.
module histogram_merge_accumulator #(
   parameter int MAX_WORDS = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   hma_req_if.sink     req_if,
   hma_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int AW   = $clog2(MAX_WORDS);
   localparam int LAST = hma_pkg::QUAD_LAT - 1;
   localparam logic [31:0] FRAC_MASK = 32'((33'd1 << FRAC_BITS) - 33'd1);

   // Configuration and derived layout limits.
   logic [1:0]  kind_ff;
   logic [10:0] bins_x_ff;
   logic [9:0]  bins_y_ff;
   logic [25:0] lim_content_ff, lim_error_ff, lim_square_ff;
   logic [25:0] lim_content_in, lim_error_in, lim_square_in;
   logic [12:0] n_w;
   logic [11:0] m_w;
   logic [24:0] cells_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= hma_pkg::KIND_1D;
         bins_x_ff <= 11'd1;
         bins_y_ff <= 10'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            hma_pkg::CSR_KIND:   kind_ff   <= csr_wdata[1:0];
            hma_pkg::CSR_BINS_X: bins_x_ff <= csr_wdata;
            hma_pkg::CSR_BINS_Y: bins_y_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      n_w     = 13'(bins_x_ff) + 13'd2;
      m_w     = 12'(bins_y_ff) + 12'd2;
      cells_w = 25'(n_w) * 25'(m_w);
      if (kind_ff == hma_pkg::KIND_2D) begin
         lim_content_in = 26'(cells_w) + 26'd8;
         lim_error_in   = (26'(cells_w) << 1) + 26'd8;
         lim_square_in  = 26'd0;
      end else begin
         lim_content_in = 26'(n_w) + 26'd5;
         lim_error_in   = (26'(n_w) << 1) + 26'd5;
         lim_square_in  = 26'(n_w) * 26'd3 + 26'd5;
      end
   end

   always_ff @(posedge clock) begin
      lim_content_ff <= lim_content_in;
      lim_error_ff   <= lim_error_in;
      lim_square_ff  <= lim_square_in;
   end

   // Stage 1: request register and classification.
   logic               s1_v_ff;
   logic [1:0]         s1_op_ff;
   logic [11:0]        s1_idx_ff;
   logic signed [31:0] s1_val_ff;
   hma_pkg::region_type s1_region;
   logic               s1_oor;
   logic [25:0]        idx_w;

   always_comb begin
      idx_w     = 26'(s1_idx_ff);
      s1_oor    = 1'b0;
      s1_region = hma_pkg::REG_HEADER;
      priority if (32'(s1_idx_ff) >= 32'(MAX_WORDS) || kind_ff == hma_pkg::KIND_NONE) begin
         s1_oor = 1'b1;
      end else if (kind_ff == hma_pkg::KIND_2D && s1_idx_ff < 12'd7) begin
         s1_region = hma_pkg::REG_HEADER;
      end else if (kind_ff == hma_pkg::KIND_2D && s1_idx_ff == 12'd7) begin
         s1_region = hma_pkg::REG_ENTRIES;
      end else if (kind_ff != hma_pkg::KIND_2D && s1_idx_ff < 12'd4) begin
         s1_region = hma_pkg::REG_HEADER;
      end else if (kind_ff != hma_pkg::KIND_2D && s1_idx_ff == 12'd4) begin
         s1_region = hma_pkg::REG_ENTRIES;
      end else if (idx_w < lim_content_ff) begin
         s1_region = hma_pkg::REG_CONTENT;
      end else if (idx_w < lim_error_ff) begin
         s1_region = hma_pkg::REG_ERROR;
      end else if (kind_ff == hma_pkg::KIND_PROF && idx_w < lim_square_ff) begin
         s1_region = hma_pkg::REG_SQUARED;
      end else begin
         s1_oor = 1'b1;
      end
   end

   // Stage 2 registers, store and write-back bypass.
   logic               s2_v_ff;
   logic [1:0]         s2_op_ff;
   logic [11:0]        s2_idx_ff;
   logic signed [31:0] s2_val_ff;
   hma_pkg::region_type s2_region_ff;
   logic               s2_oor_ff;

   logic [31:0]        mem [0:MAX_WORDS-1];
   logic [31:0]        rd_ff;
   logic [AW-1:0]      rd_addr;
   logic               wb_v_ff;
   logic [11:0]        wb_idx_ff;
   logic [31:0]        wb_data_ff;

   hma_pkg::rec_type   tail_ff [0:LAST];
   hma_pkg::rec_type   t0_rec;
   hma_pkg::rec_type   fin;
   hma_pkg::rsp_type   fin_rsp, out_ff, skid_ff;
   logic               out_v_ff, skid_v_ff;
   logic               pipe_adv, s2_hold, s2_take, hazard, wr_en;
   logic [31:0]        q_a, q_b, q_root;
   logic               q_sat;

   assign pipe_adv = !skid_v_ff;

   // A word still in the tail for the same index has not reached the store.
   always_comb begin
      hazard = 1'b0;
      for (int j = 0; j <= LAST; j++) begin
         if (tail_ff[j].v && tail_ff[j].wr && tail_ff[j].idx == s2_idx_ff) begin
            hazard = 1'b1;
         end
      end
   end

   assign s2_hold = s2_v_ff && !s2_oor_ff && hazard;
   assign s2_take = pipe_adv && !s2_hold;
   assign req_if.ready = s2_take;
   assign rd_addr = s2_take ? AW'(s1_idx_ff) : AW'(s2_idx_ff);

   function automatic logic [32:0] sat_add(input logic signed [31:0] x,
                                           input logic signed [31:0] y);
      logic signed [32:0] s;
      logic [32:0]        r;
      s = 33'(x) + 33'(y);
      if (s > 33'(hma_pkg::S32_MAX)) begin
         r = {1'b1, hma_pkg::S32_MAX};
      end else if (s < 33'(hma_pkg::S32_MIN)) begin
         r = {1'b1, hma_pkg::S32_MIN};
      end else begin
         r = {1'b0, s[31:0]};
      end
      return r;
   endfunction

   // Stage 2 compute.
   always_comb begin
      logic signed [31:0] cur;
      logic signed [31:0] ipart;
      logic [31:0]        mag;
      logic [32:0]        sr;
      cur   = (wb_v_ff && wb_idx_ff == s2_idx_ff) ? wb_data_ff : rd_ff;
      mag   = s2_val_ff[31] ? 32'(-s2_val_ff) : 32'(s2_val_ff);
      mag   = mag & ~FRAC_MASK;
      ipart = s2_val_ff[31] ? -$signed(mag) : $signed(mag);
      q_a   = cur[31] ? 32'(-cur) : 32'(cur);
      q_b   = s2_val_ff[31] ? 32'(-s2_val_ff) : 32'(s2_val_ff);
      sr    = 33'd0;

      t0_rec        = '0;
      t0_rec.v      = s2_v_ff && !s2_hold;
      t0_rec.wr     = !s2_oor_ff;
      t0_rec.idx    = s2_idx_ff;
      t0_rec.oor    = s2_oor_ff;
      t0_rec.region = s2_oor_ff ? hma_pkg::REG_HEADER : s2_region_ff;
      t0_rec.data   = cur;
      if (!s2_oor_ff) begin
         unique case (s2_op_ff)
            hma_pkg::OP_INIT: begin
               t0_rec.data = s2_val_ff;
               if (kind_ff == hma_pkg::KIND_2D && s2_region_ff == hma_pkg::REG_ERROR) begin
                  if (s2_val_ff == hma_pkg::S32_MIN) begin
                     t0_rec.data = hma_pkg::S32_MAX;
                     t0_rec.sat  = 1'b1;
                  end else begin
                     t0_rec.data = q_b;
                  end
               end
            end
            hma_pkg::OP_ACCUM: begin
               priority if (s2_region_ff == hma_pkg::REG_HEADER) begin
                  t0_rec.data = cur;
               end else if (s2_region_ff == hma_pkg::REG_ENTRIES) begin
                  sr          = sat_add(cur, ipart);
                  t0_rec.data = sr[31:0];
                  t0_rec.sat  = sr[32];
               end else if (s2_region_ff == hma_pkg::REG_ERROR &&
                            kind_ff != hma_pkg::KIND_PROF) begin
                  t0_rec.pend = 1'b1;
               end else begin
                  sr          = sat_add(cur, s2_val_ff);
                  t0_rec.data = sr[31:0];
                  t0_rec.sat  = sr[32];
               end
            end
            default: t0_rec.data = cur;
         endcase
      end else begin
         t0_rec.data = 32'd0;
      end
   end

   hma_quad_pipe u_quad (
      .clock (clock),
      .en    (pipe_adv),
      .a     (q_a),
      .b     (q_b),
      .root  (q_root),
      .sat   (q_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         for (int j = 0; j <= LAST; j++) begin
            tail_ff[j].v <= 1'b0;
         end
      end else if (pipe_adv) begin
         if (!s2_hold) begin
            s1_v_ff      <= req_if.valid;
            s1_op_ff     <= req_if.op;
            s1_idx_ff    <= req_if.word_index;
            s1_val_ff    <= req_if.value;
            s2_v_ff      <= s1_v_ff;
            s2_op_ff     <= s1_op_ff;
            s2_idx_ff    <= s1_idx_ff;
            s2_val_ff    <= s1_val_ff;
            s2_region_ff <= s1_region;
            s2_oor_ff    <= s1_oor;
         end
         tail_ff[0] <= t0_rec;
         for (int j = 1; j <= LAST; j++) begin
            tail_ff[j] <= tail_ff[j-1];
         end
      end
   end

   assign fin            = tail_ff[LAST];
   assign fin_rsp.data   = fin.pend ? q_root : fin.data;
   assign fin_rsp.region = fin.region;
   assign fin_rsp.oor    = fin.oor;
   assign fin_rsp.sat    = fin.pend ? q_sat : fin.sat;
   assign wr_en          = pipe_adv && fin.v && fin.wr;

   // Store: read data registered; a read in the cycle of a write sees the old word.
   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[AW'(fin.idx)] <= fin_rsp.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_v_ff <= 1'b0;
      end else begin
         wb_v_ff <= wr_en;
      end
      wb_idx_ff  <= fin.idx;
      wb_data_ff <= fin_rsp.data;
   end

   // Output register with a skid word behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_if.ready) begin
         if (skid_v_ff) begin
            out_ff    <= skid_ff;
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_ff   <= fin_rsp;
            out_v_ff <= fin.v;
         end
      end else if (fin.v && pipe_adv) begin
         skid_ff   <= fin_rsp;
         skid_v_ff <= 1'b1;
      end
   end

   assign rsp_if.valid        = out_v_ff;
   assign rsp_if.result_value = out_ff.data;
   assign rsp_if.region       = out_ff.region;
   assign rsp_if.out_of_range = out_ff.oor;
   assign rsp_if.saturated    = out_ff.sat;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid word held without a pending output word");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> !req_if.ready)
      else $error("request accepted while the pipeline is stalled");

   a_oor_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.out_of_range |->
         rsp_if.result_value == 32'sd0 && !rsp_if.saturated &&
         rsp_if.region == hma_pkg::REG_HEADER)
      else $error("out-of-range response carries data");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      s2_hold |-> s2_v_ff && !wr_en || s2_v_ff)
      else $error("compute stage held without a word");

endmodule

// File: test/tb_histogram_merge_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_histogram_merge_accumulator
// Drives layouts of every kind with init, accumulate and read words and
// compares each response word against a cycle-free predictor of the sum store.
// ----------------------------------------------------------------------------

typedef struct {
   logic signed [31:0] data;
   logic [2:0]         region;
   logic               oor;
   logic               sat;
} sum_word_type;

class merge_scoreboard;
   logic [31:0]  store [4096];
   bit           written [4096];
   logic [1:0]   kind;
   logic [10:0]  nx;
   logic [9:0]   ny;
   sum_word_type pending [$];
   int           errors;

   function new();
      kind = hma_pkg::KIND_1D;
      nx = 11'd1;
      ny = 10'd1;
      errors = 0;
      foreach (written[i]) written[i] = 0;
   endfunction

   function void set_reg(logic [1:0] index, logic [10:0] data);
      case (index)
         hma_pkg::CSR_KIND: kind = data[1:0];
         hma_pkg::CSR_BINS_X: nx = data;
         hma_pkg::CSR_BINS_Y: ny = data[9:0];
         default: ;
      endcase
   endfunction

   // Number of words in the current layout, capped at the store size.
   function int layout_words();
      longint n, m, total;
      n = nx + 2;
      m = ny + 2;
      if (kind == hma_pkg::KIND_1D) total = 5 + 2 * n;
      else if (kind == hma_pkg::KIND_PROF) total = 5 + 3 * n;
      else if (kind == hma_pkg::KIND_2D) total = 8 + 2 * n * m;
      else total = 0;
      return (total > 4096) ? 4096 : int'(total);
   endfunction

   function int region_of(int idx);
      longint n, m;
      n = nx + 2;
      m = ny + 2;
      if (idx >= layout_words()) return -1;
      if (kind == hma_pkg::KIND_2D) begin
         if (idx < 7) return hma_pkg::REG_HEADER;
         if (idx == 7) return hma_pkg::REG_ENTRIES;
         if (idx < 8 + n * m) return hma_pkg::REG_CONTENT;
         return hma_pkg::REG_ERROR;
      end
      if (idx < 4) return hma_pkg::REG_HEADER;
      if (idx == 4) return hma_pkg::REG_ENTRIES;
      if (idx < 5 + n) return hma_pkg::REG_CONTENT;
      if (idx < 5 + 2 * n) return hma_pkg::REG_ERROR;
      return hma_pkg::REG_SQUARED;
   endfunction

   function longint saturate(longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function longint unsigned root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function void note(logic [1:0] op, logic [11:0] idx, logic signed [31:0] value);
      sum_word_type w;
      int rg;
      longint cur, val, res, mag;
      longint unsigned a, b, r;
      bit sat;
      rg = region_of(idx);
      sat = 0;
      if (rg < 0) begin
         w.data = 0;
         w.region = 0;
         w.oor = 1;
         w.sat = 0;
         pending.push_back(w);
         return;
      end
      cur = longint'($signed(store[idx]));
      val = longint'(value);
      res = cur;
      if (op == hma_pkg::OP_INIT) begin
         res = val;
         if (kind == hma_pkg::KIND_2D && rg == hma_pkg::REG_ERROR)
            res = saturate(val < 0 ? -val : val, sat);
      end else if (op == hma_pkg::OP_ACCUM) begin
         if (rg == hma_pkg::REG_ENTRIES) begin
            // Only the integer part counts, truncated toward zero.
            mag = (val < 0) ? -val : val;
            mag = mag & ~longint'(64'hFFFF);
            res = saturate(cur + ((val < 0) ? -mag : mag), sat);
         end else if (rg == hma_pkg::REG_ERROR && kind != hma_pkg::KIND_PROF) begin
            a = (cur < 0) ? -cur : cur;
            b = (val < 0) ? -val : val;
            r = root_floor(a * a + b * b);
            if (r > 64'd2147483647) begin
               sat = 1;
               r = 64'd2147483647;
            end
            res = longint'(r);
         end else if (rg != hma_pkg::REG_HEADER) begin
            res = saturate(cur + val, sat);
         end
      end
      store[idx] = res[31:0];
      written[idx] = 1;
      w.data = res[31:0];
      w.region = rg[2:0];
      w.oor = 0;
      w.sat = sat;
      pending.push_back(w);
   endfunction

   function void check(logic signed [31:0] data, logic [2:0] region, logic oor, logic sat);
      sum_word_type w;
      if (pending.size() == 0) begin
         $error("response word with nothing expected: data %h", data);
         errors++;
         return;
      end
      w = pending.pop_front();
      if (data !== w.data) begin
         $error("result_value: expected %h, actual %h", w.data, data);
         errors++;
      end
      if (region !== w.region) begin
         $error("region: expected %0d, actual %0d", w.region, region);
         errors++;
      end
      if (oor !== w.oor) begin
         $error("out_of_range: expected %0d, actual %0d", w.oor, oor);
         errors++;
      end
      if (sat !== w.sat) begin
         $error("saturated: expected %0d, actual %0d", w.sat, sat);
         errors++;
      end
   endfunction
endclass

module tb_histogram_merge_accumulator;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [1:0]  csr_index = hma_pkg::CSR_KIND;
   logic [10:0] csr_wdata = 0;

   hma_req_if req ();
   hma_rsp_if rsp ();

   histogram_merge_accumulator DUT (
      .clock(clock), .reset(reset), .req_if(req), .rsp_if(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   merge_scoreboard sums = new();
   bit  calm = 0;
   int  rsp_count = 0;
   int  quiet_cycles = 0;

   initial begin
      req.valid = 0;
      req.op = hma_pkg::OP_INIT;
      req.word_index = 0;
      req.value = 0;
      rsp.ready = 0;
   end

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Ends the run if no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
         $display("tb_histogram_merge_accumulator: done, errors");
         $finish;
      end
   end

   // Response side: random stalls, and once a long hold-off that backs up the block.
   initial begin
      int idle_left;
      int hold_left;
      bit held;
      idle_left = 0;
      hold_left = 0;
      held = 0;
      forever begin
         @(negedge clock);
         if (!held && rsp_count >= 400) begin
            held = 1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready = 0;
         end else if (calm) begin
            rsp.ready = 1;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp.ready = 0;
         end else if ($urandom_range(99) < 15) begin
            idle_left = $urandom_range(4);
            rsp.ready = 0;
         end else begin
            rsp.ready = 1;
         end
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            sums.check(rsp.result_value, rsp.region, rsp.out_of_range, rsp.saturated);
            rsp_count++;
         end
      end
   end

   // All tasks start and end at a falling edge.
   task automatic send_word(logic [1:0] op, logic [11:0] idx, logic [31:0] value);
      req.valid = 1;
      req.op = op;
      req.word_index = idx;
      req.value = value;
      do @(posedge clock); while (!req.ready);
      sums.note(op, idx, value);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      req.valid = 0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [10:0] data);
      csr_we = 1;
      csr_index = index;
      csr_wdata = data;
      sums.set_reg(index, data);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic drain();
      req.valid = 0;
      while (sums.pending.size() != 0) @(negedge clock);
      repeat (45) @(negedge clock);
   endtask

   task automatic set_layout(logic [1:0] kind, logic [10:0] bx, logic [9:0] by);
      drain();
      write_reg(hma_pkg::CSR_KIND, {9'd0, kind});
      write_reg(hma_pkg::CSR_BINS_X, bx);
      write_reg(hma_pkg::CSR_BINS_Y, {1'b0, by});
   endtask

   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 10) begin
         case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0;
         endcase
      end
      if (sel < 50) return $urandom_range(32'h1FFFFF) - 32'h10_0000;
      if (sel < 75) return $urandom_range(32'h7FFFFFF) - 32'h400_0000;
      return $urandom;
   endfunction

   task automatic random_words(int count, bit quiet_end);
      int words, sel, k;
      logic [11:0] idx;
      logic [1:0] op;
      words = sums.layout_words();
      for (k = 0; k < count; k++) begin
         if (quiet_end && k == count - 150) calm = 1;
         sel = $urandom_range(99);
         if (words == 0 || sel < 8) idx = 12'($urandom_range(4095));
         else if (sel < 75) idx = 12'($urandom_range((words < 200 ? words : 200) - 1));
         else idx = 12'($urandom_range(words - 1));
         sel = $urandom_range(99);
         if (sel < 15) op = hma_pkg::OP_INIT;
         else if (sel < 75) op = hma_pkg::OP_ACCUM;
         else if (sel < 92) op = hma_pkg::OP_READ;
         else op = hma_pkg::OP_SPARE;
         // Never accumulate into or read a word that holds nothing yet; init it instead.
         if (sums.region_of(idx) >= 0 && !sums.written[idx]) op = hma_pkg::OP_INIT;
         send_word(op, idx, pick_value());
         if (!calm && $urandom_range(99) < 12) pause_sender($urandom_range(1, 5));
      end
   endtask

   initial begin
      int i;
      repeat (4) @(negedge clock);
      reset = 0;
      @(negedge clock);

      // One-dimensional, single bin: header 0..3, entries 4, contents 5..7, errors 8..10.
      for (i = 0; i <= 10; i++) send_word(hma_pkg::OP_INIT, i[11:0], 32'h0001_8000 * i);
      send_word(hma_pkg::OP_ACCUM, 12'd2, 32'h1234_5678);
      send_word(hma_pkg::OP_ACCUM, 12'd4, 32'hFFFE_8000);
      send_word(hma_pkg::OP_ACCUM, 12'd4, 32'h0003_C000);
      send_word(hma_pkg::OP_INIT, 12'd6, 32'h7FFF_0000);
      send_word(hma_pkg::OP_ACCUM, 12'd6, 32'h7FFF_FFFF);
      send_word(hma_pkg::OP_INIT, 12'd7, 32'h8000_0000);
      send_word(hma_pkg::OP_ACCUM, 12'd7, 32'h8000_0000);
      send_word(hma_pkg::OP_ACCUM, 12'd9, 32'h8000_0000);
      send_word(hma_pkg::OP_ACCUM, 12'd8, 32'hFFFD_0000);
      send_word(hma_pkg::OP_READ, 12'd9, 32'h0);
      send_word(hma_pkg::OP_SPARE, 12'd8, 32'hFFFF_FFFF);
      send_word(hma_pkg::OP_ACCUM, 12'd11, 32'h1);
      send_word(hma_pkg::OP_READ, 12'd4095, 32'h0);

      // Two-dimensional: init of an error word stores its magnitude.
      set_layout(hma_pkg::KIND_2D, 11'd1, 10'd1);
      send_word(hma_pkg::OP_INIT, 12'd20, 32'h8000_0000);
      send_word(hma_pkg::OP_INIT, 12'd21, 32'hFFF0_0000);
      send_word(hma_pkg::OP_ACCUM, 12'd21, 32'h0003_0000);
      drain();

      random_words(150, 0);
      set_layout(hma_pkg::KIND_2D, 11'd5, 10'd3);
      random_words(170, 0);
      set_layout(hma_pkg::KIND_PROF, 11'd2040, 10'd1022);
      random_words(170, 0);
      set_layout(hma_pkg::KIND_1D, 11'd2040, 10'd1);
      random_words(140, 0);
      set_layout(hma_pkg::KIND_NONE, 11'd4, 10'd4);
      random_words(30, 0);
      set_layout(hma_pkg::KIND_2D, 11'd1, 10'd1022);
      random_words(120, 0);
      set_layout(hma_pkg::KIND_1D, 11'd0, 10'd0);
      random_words(30, 0);
      set_layout(hma_pkg::KIND_PROF, 11'd3, 10'd1);
      random_words(220, 1);

      req.valid = 0;
      while (sums.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (sums.errors == 0) $display("tb_histogram_merge_accumulator: done, clean");
      else $display("tb_histogram_merge_accumulator: done, errors");
      $finish;
   end
endmodule
